### hdl/cd_pkg.sv
// shared types and constants of the call dispatcher
package cd_pkg;

	localparam int CALL_W = 31;
	localparam int HCNT_W = 32;
	localparam int WAIT_W = 16;

	localparam logic [4:0] SCOUNT_RESET = 5'd16;

	// action codes
	localparam logic [1:0] ACT_ADD  = 2'd0;
	localparam logic [1:0] ACT_DIST = 2'd1;
	localparam logic [1:0] ACT_DONE = 2'd2;

	// result status codes
	localparam logic [3:0] ST_QUEUED       = 4'd0;
	localparam logic [3:0] ST_BAD_CALL     = 4'd1;
	localparam logic [3:0] ST_FULL         = 4'd2;
	localparam logic [3:0] ST_ASSIGNED     = 4'd3;
	localparam logic [3:0] ST_EMPTY        = 4'd4;
	localparam logic [3:0] ST_ALL_BUSY     = 4'd5;
	localparam logic [3:0] ST_BAD_SERVER   = 4'd6;
	localparam logic [3:0] ST_ALREADY_FREE = 4'd7;
	localparam logic [3:0] ST_COMPLETED    = 4'd8;

	// call queue controls
	typedef struct packed {
		logic rd_en;
		logic push;
		logic pop;
	} q_ctrl_t;

	// server bank controls
	typedef struct packed {
		logic rd_en;
		logic assign_en;
		logic free_en;
	} srv_ctrl_t;

endpackage

### hdl/cd_if.sv
// valid/ready channel interfaces for dispatch requests and results
interface cd_item_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic signed [31:0] call_id;
	logic [7:0]        server_id;

	modport source(output valid, action, call_id, server_id, input ready);
	modport sink(input valid, action, call_id, server_id, output ready);
endinterface

interface cd_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [4:0]  named_server;
	logic [30:0] finished_call;
	logic [31:0] handled_total;
	logic [4:0]  assigned_server;
	logic [30:0] assigned_call;
	logic [4:0]  queued_count;
	logic [19:0] waiting_minutes;
	logic        any_busy;

	modport source(output valid, status, named_server, finished_call, handled_total,
		assigned_server, assigned_call, queued_count, waiting_minutes, any_busy,
		input ready);
	modport sink(input valid, status, named_server, finished_call, handled_total,
		assigned_server, assigned_call, queued_count, waiting_minutes, any_busy,
		output ready);
endinterface

### hdl/call_dispatcher.sv
// call dispatcher top level: request decode, read-modify-write pass and result register
// a taken transaction is held until the result register is free, then committed into it;
// one transaction at a time: the queue and server memories are read in the accept cycle
//   and written back at commit, which waits for a free result register, and input ready
//   stays low over that pass
// reset: queue pointers, fill count, busy flags, handled-count valid bits and the
//   wait counter clear at once; server_count returns to 16; no memory clearing pass
module call_dispatcher #(
	parameter int MAX_SERVERS = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	cd_item_if.sink           item,
	cd_result_if.source       result,
	input  logic              cfg_we,
	input  logic [4:0]        cfg_wdata
);

	localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	// control state
	logic                      pend_q;
	logic                      oval_q;
	logic [4:0]                scount_q;
	logic [cd_pkg::WAIT_W-1:0] wait_q;

	// request captured for the write-back pass
	logic [1:0]        act_s1;
	logic signed [31:0] call_s1;
	logic [7:0]        sid_s1;

	// result register
	logic [3:0]                status_q;
	logic [4:0]                named_q;
	logic [cd_pkg::CALL_W-1:0] fin_q;
	logic [cd_pkg::HCNT_W-1:0] htot_q;
	logic [4:0]                asrv_q;
	logic [cd_pkg::CALL_W-1:0] acall_q;
	logic [4:0]                qcnt_q;
	logic [19:0]               wmin_q;
	logic                      anyb_q;

	// memory side
	cd_pkg::q_ctrl_t           qc;
	cd_pkg::srv_ctrl_t         sc;
	logic [cd_pkg::CALL_W-1:0] q_rd;
	logic [FW-1:0]             q_fill;
	logic [MAX_SERVERS-1:0]    busy;
	logic [cd_pkg::CALL_W-1:0] cur_rd;
	logic [cd_pkg::HCNT_W-1:0] hcnt_rd;

	// pass logic
	logic                      acc;
	logic                      commit;
	logic [7:0]                n_eff;
	logic [MAX_SERVERS-1:0]    in_use;
	logic [MAX_SERVERS-1:0]    ff_mask;
	logic [MAX_SERVERS-1:0]    busy_nx;
	logic                      ff_found;
	logic [IW-1:0]             ff_idx;
	logic                      sid_ok;
	logic [IW-1:0]             sidx;
	logic                      sid_busy;
	logic [cd_pkg::HCNT_W-1:0] hcnt_new;
	logic [3:0]                st_d;
	logic [4:0]                named_d;
	logic [cd_pkg::CALL_W-1:0] fin_d;
	logic [cd_pkg::HCNT_W-1:0] htot_d;
	logic [4:0]                asrv_d;
	logic [cd_pkg::CALL_W-1:0] acall_d;
	logic [cd_pkg::WAIT_W-1:0] wait_d;
	logic [FW-1:0]             fill_nx;

	// one transaction in flight; the result register may still hold the previous one
	assign item.ready = !pend_q;
	assign acc        = item.valid && item.ready;
	assign commit     = pend_q && (!oval_q || result.ready);

	cd_call_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (qc),
		.push_data (call_s1[cd_pkg::CALL_W-1:0]),
		.rd_data   (q_rd),
		.fill      (q_fill)
	);

	cd_server_bank #(
		.NSRV (MAX_SERVERS),
		.IW   (IW)
	) u_servers (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (sc),
		.rd_idx     (IW'(item.server_id - 8'd1)),
		.asg_idx    (ff_idx),
		.asg_call   (q_rd),
		.free_idx   (sidx),
		.hcnt_wdata (hcnt_new),
		.busy       (busy),
		.cur_rd     (cur_rd),
		.hcnt_rd    (hcnt_rd)
	);

	// servers in use: a count of zero acts as one, too large a count as the maximum
	always_comb begin
		if (scount_q == 5'd0) begin
			n_eff = 8'd1;
		end else if ({3'b000, scount_q} > 8'(MAX_SERVERS)) begin
			n_eff = 8'(MAX_SERVERS);
		end else begin
			n_eff = {3'b000, scount_q};
		end
		for (int i = 0; i < MAX_SERVERS; i++) begin
			in_use[i] = (8'(i) < n_eff);
		end
	end

	assign sid_ok   = (sid_s1 != 8'd0) && (sid_s1 <= n_eff);
	assign sidx     = IW'(sid_s1 - 8'd1);
	assign sid_busy = sid_ok && busy[sidx];
	assign hcnt_new = (hcnt_rd == '1) ? hcnt_rd : hcnt_rd + cd_pkg::HCNT_W'(1);

	// lowest free server; a server freed by complete counts as free for auto distribute
	always_comb begin
		ff_mask = ~busy & in_use;
		if (act_s1 == cd_pkg::ACT_DONE && sid_busy) begin
			ff_mask[sidx] = 1'b1;
		end
		ff_found = |ff_mask;
		ff_idx   = '0;
		for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
			if (ff_mask[i]) begin
				ff_idx = IW'(i);
			end
		end
	end

	// decode of the captured request
	always_comb begin
		// memory reads go out with the accepted transaction
		qc.rd_en     = acc;
		sc.rd_en     = acc;
		st_d         = cd_pkg::ST_BAD_CALL;
		named_d      = '0;
		fin_d        = '0;
		htot_d       = '0;
		asrv_d       = '0;
		acall_d      = '0;
		wait_d       = wait_q;
		qc.push      = 1'b0;
		qc.pop       = 1'b0;
		sc.assign_en = 1'b0;
		sc.free_en   = 1'b0;
		unique case (act_s1)
			cd_pkg::ACT_ADD: begin
				if (call_s1[31] || call_s1 == 32'sd0) begin
					st_d = cd_pkg::ST_BAD_CALL;
				end else if (q_fill >= FW'(QUEUE_DEPTH)) begin
					st_d = cd_pkg::ST_FULL;
				end else begin
					st_d    = cd_pkg::ST_QUEUED;
					qc.push = commit;
					if (!ff_found && wait_q != '1) begin
						wait_d = wait_q + cd_pkg::WAIT_W'(1);
					end
				end
			end
			cd_pkg::ACT_DIST: begin
				if (q_fill == '0) begin
					st_d = cd_pkg::ST_EMPTY;
				end else if (!ff_found) begin
					st_d = cd_pkg::ST_ALL_BUSY;
				end else begin
					st_d         = cd_pkg::ST_ASSIGNED;
					qc.pop       = commit;
					sc.assign_en = commit;
					asrv_d       = 5'({1'b0, ff_idx} + (IW + 1)'(1));
					acall_d      = q_rd;
				end
			end
			cd_pkg::ACT_DONE: begin
				if (!sid_ok) begin
					st_d = cd_pkg::ST_BAD_SERVER;
				end else if (!sid_busy) begin
					st_d    = cd_pkg::ST_ALREADY_FREE;
					named_d = sid_s1[4:0];
					htot_d  = hcnt_rd;
				end else begin
					st_d       = cd_pkg::ST_COMPLETED;
					named_d    = sid_s1[4:0];
					fin_d      = cur_rd;
					htot_d     = hcnt_new;
					sc.free_en = commit;
					// waiting calls go straight to the lowest free server
					if (q_fill != '0) begin
						qc.pop       = commit;
						sc.assign_en = commit;
						asrv_d       = 5'({1'b0, ff_idx} + (IW + 1)'(1));
						acall_d      = q_rd;
					end
				end
			end
			default: begin
				st_d = cd_pkg::ST_BAD_CALL;
			end
		endcase
	end

	// view of busy flags and fill after this pass
	always_comb begin
		busy_nx = busy;
		if (sc.free_en) begin
			busy_nx[sidx] = 1'b0;
		end
		if (sc.assign_en) begin
			busy_nx[ff_idx] = 1'b1;
		end
		fill_nx = q_fill;
		if (qc.push) begin
			fill_nx = q_fill + FW'(1);
		end else if (qc.pop) begin
			fill_nx = q_fill - FW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b0;
			oval_q   <= 1'b0;
			scount_q <= cd_pkg::SCOUNT_RESET;
			wait_q   <= '0;
		end else begin
			if (cfg_we) begin
				scount_q <= cfg_wdata;
			end
			if (acc) begin
				pend_q <= 1'b1;
			end else if (commit) begin
				pend_q <= 1'b0;
			end
			if (commit) begin
				oval_q <= 1'b1;
				wait_q <= wait_d;
			end else if (result.ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_s1  <= item.action;
			call_s1 <= item.call_id;
			sid_s1  <= item.server_id;
		end
		if (commit) begin
			status_q <= st_d;
			named_q  <= named_d;
			fin_q    <= fin_d;
			htot_q   <= htot_d;
			asrv_q   <= asrv_d;
			acall_q  <= acall_d;
			qcnt_q   <= 5'(fill_nx);
			// wait counter times ten as two shifted adds
			wmin_q   <= 20'({wait_d, 3'b000}) + 20'({wait_d, 1'b0});
			anyb_q   <= |(busy_nx & in_use);
		end
	end

	assign result.valid           = oval_q;
	assign result.status          = status_q;
	assign result.named_server    = named_q;
	assign result.finished_call   = fin_q;
	assign result.handled_total   = htot_q;
	assign result.assigned_server = asrv_q;
	assign result.assigned_call   = acall_q;
	assign result.queued_count    = qcnt_q;
	assign result.waiting_minutes = wmin_q;
	assign result.any_busy        = anyb_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_fill <= FW'(QUEUE_DEPTH))
		else $error("queue fill above depth");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> pend_q && !item.ready)
		else $error("new transaction taken during write-back pass");

	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> result.valid && result.queued_count == 5'(q_fill))
		else $error("result does not match queue fill after commit");

	a_assign_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.assigned_server != 5'd0 |->
			(result.status == cd_pkg::ST_ASSIGNED || result.status == cd_pkg::ST_COMPLETED))
		else $error("assigned server with wrong status");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		qc.pop |-> q_fill != '0 && sc.assign_en)
		else $error("queue pop without assignment or from empty queue");
`endif

endmodule

### hdl/cd_call_queue.sv
// call id queue: circular buffer memory with head, tail and fill count
module cd_call_queue #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cd_pkg::q_ctrl_t            ctrl,
	input  logic [cd_pkg::CALL_W-1:0]  push_data,
	output logic [cd_pkg::CALL_W-1:0]  rd_data,
	output logic [$clog2(DEPTH+1)-1:0] fill
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);

	logic [cd_pkg::CALL_W-1:0] mem [DEPTH];
	logic [cd_pkg::CALL_W-1:0] rd_q;
	logic [AW-1:0]             head_q;
	logic [AW-1:0]             tail_q;
	logic [FW-1:0]             fill_q;

	function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= wrap_next(tail_q);
				fill_q <= fill_q + FW'(1);
			end else if (ctrl.pop) begin
				head_q <= wrap_next(head_q);
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	// head entry is read when a transaction is taken, written back entries at commit
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= push_data;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem[head_q];
		end
	end

	assign rd_data = rd_q;
	assign fill    = fill_q;

endmodule

### hdl/cd_server_bank.sv
// per-server state: busy flags, current call memory, handled count memory
module cd_server_bank #(
	parameter int NSRV = 16,
	parameter int IW   = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cd_pkg::srv_ctrl_t         ctrl,
	input  logic [IW-1:0]             rd_idx,
	input  logic [IW-1:0]             asg_idx,
	input  logic [cd_pkg::CALL_W-1:0] asg_call,
	input  logic [IW-1:0]             free_idx,
	input  logic [cd_pkg::HCNT_W-1:0] hcnt_wdata,
	output logic [NSRV-1:0]           busy,
	output logic [cd_pkg::CALL_W-1:0] cur_rd,
	output logic [cd_pkg::HCNT_W-1:0] hcnt_rd
);

	logic [cd_pkg::CALL_W-1:0] cur_mem  [NSRV];
	logic [cd_pkg::HCNT_W-1:0] hcnt_mem [NSRV];
	logic [NSRV-1:0]           busy_q;
	logic [NSRV-1:0]           busy_d;
	logic [NSRV-1:0]           hvalid_q;
	logic [cd_pkg::CALL_W-1:0] cur_rd_q;
	logic [cd_pkg::HCNT_W-1:0] hcnt_rd_q;
	logic                      hval_q;

	// assign after free so a server freed and reloaded in one pass stays busy
	always_comb begin
		busy_d = busy_q;
		if (ctrl.free_en) begin
			busy_d[free_idx] = 1'b0;
		end
		if (ctrl.assign_en) begin
			busy_d[asg_idx] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= '0;
			hvalid_q <= '0;
		end else begin
			busy_q <= busy_d;
			if (ctrl.free_en) begin
				hvalid_q[free_idx] <= 1'b1;
			end
		end
	end

	// a current call is only used while its server is busy, so it needs no clear
	always_ff @(posedge clk) begin
		if (ctrl.assign_en) begin
			cur_mem[asg_idx] <= asg_call;
		end
		if (ctrl.free_en) begin
			hcnt_mem[free_idx] <= hcnt_wdata;
		end
		if (ctrl.rd_en) begin
			cur_rd_q  <= cur_mem[rd_idx];
			hcnt_rd_q <= hcnt_mem[rd_idx];
			hval_q    <= hvalid_q[rd_idx];
		end
	end

	assign busy    = busy_q;
	assign cur_rd  = cur_rd_q;
	assign hcnt_rd = hval_q ? hcnt_rd_q : '0;

endmodule
